// ===== design/mfi_pkg.sv =====
package mfi_pkg;

  // Sizing of the block.
  localparam int MAX_WINDOW  = 64;
  localparam int PRICE_BITS  = 24;
  localparam int VOLUME_BITS = 32;
  localparam int CFG_W       = 7;
  localparam int MFI_W       = 15;

  // Derived widths.
  localparam int RING_AW  = $clog2(MAX_WINDOW);
  localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
  localparam int TP_SUM_W = PRICE_BITS + 2;
  localparam int FLOW_W   = PRICE_BITS + VOLUME_BITS;
  localparam int ENTRY_W  = FLOW_W + 1;
  localparam int SUM_W    = FLOW_W + RING_AW;
  localparam int TOTAL_W  = SUM_W + 1;
  localparam int NUM_W    = SUM_W + MFI_W;
  localparam int Q_CNT_W  = $clog2(MFI_W);

  // Full scale of the index: 100 in units of 1/256.
  localparam logic [MFI_W-1:0] FULL_SCALE = MFI_W'(25600);

  // Reset value of the window length register.
  localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(14);

  // Reciprocal of three, scaled by 2**TP_SUM_W, for the typical price.
  localparam logic [63:0] ONE64 = 64'd1;
  localparam logic [TP_SUM_W-1:0] RECIP3 = TP_SUM_W'((ONE64 << TP_SUM_W) / 64'd3);

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TYPICAL,
    ST_FLOW,
    ST_SUM,
    ST_LAST,
    ST_TOTAL,
    ST_NUM_A,
    ST_NUM_B,
    ST_START,
    ST_DIV,
    ST_PUT
  } state_t;

  // Status of the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== design/mfi_bar_if.sv =====
interface mfi_bar_if import mfi_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [PRICE_BITS-1:0]  bar_low;
  logic [PRICE_BITS-1:0]  bar_high;
  logic [PRICE_BITS-1:0]  bar_close;
  logic [VOLUME_BITS-1:0] bar_volume;

  modport source (output valid, bar_low, bar_high, bar_close, bar_volume, input ready);
  modport sink (input valid, bar_low, bar_high, bar_close, bar_volume, output ready);
endinterface

// ===== design/mfi_res_if.sv =====
interface mfi_res_if import mfi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MFI_W-1:0] mfi_value;

  modport source (output valid, mfi_value, input ready);
  modport sink (input valid, mfi_value, output ready);
endinterface

// ===== design/mfi_ram.sv =====
module mfi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/mfi_div.sv =====
module mfi_div import mfi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NUM_W-1:0]   numer,
  input  logic [TOTAL_W-1:0] denom,
  output div_stat_t          stat,
  output logic [MFI_W-1:0]   quotient
);

  logic [TOTAL_W-1:0] rem;
  logic [TOTAL_W-1:0] rem_next;
  logic [TOTAL_W-1:0] den;
  logic [MFI_W-1:0]   low_bits;
  logic [Q_CNT_W-1:0] cnt;
  logic               busy;
  logic               done;
  logic [TOTAL_W:0]   trial;
  logic [TOTAL_W:0]   diff;
  logic               take;

  // One restoring step: bring down the next numerator bit and try to subtract.
  // The upper numerator bits are known to stay below the divisor, so they load
  // straight into the remainder and only the low quotient bits are iterated.
  always_comb begin
    trial    = {rem, low_bits[MFI_W-1]};
    diff     = trial - {1'b0, den};
    take     = trial >= {1'b0, den};
    rem_next = take ? diff[TOTAL_W-1:0] : trial[TOTAL_W-1:0];
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == Q_CNT_W'(MFI_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == Q_CNT_W'(MFI_W - 1)) begin
          busy <= 1'b0;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Remainder, numerator bits and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= TOTAL_W'(numer[NUM_W-1:MFI_W]);
      low_bits <= numer[MFI_W-1:0];
      den      <= denom;
      quotient <= '0;
    end else if (busy) begin
      rem      <= rem_next;
      low_bits <= {low_bits[MFI_W-2:0], 1'b0};
      quotient <= {quotient[MFI_W-2:0], take};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== design/money_flow_index.sv =====
// Money flow index over a stream of price bars. Each accepted bar gives a
// typical price (low + high + close) / 3, truncated; the first bar after reset
// only stores it. Every later bar stores its money flow (typical price times
// volume) in a 64-entry ring, marked negative when the typical price fell.
// Once window_length flows exist, the bar yields mfi_value = 25600 * P / (P + N),
// truncated, where P and N are the positive and negative sums over the latest
// window_length flows: 25600 when there is no negative flow, 0 when there is
// no positive flow. window_length is taken as 1 when written 0 and as 64 when
// written larger; a write applies from the next bar to reach its flow step.
// One bar at a time is in work: a bar that yields a result holds the input
// off until its result is handed to the output register, while it reads the
// ring one entry per cycle through the memory's single read port and runs the
// 15-step serial divider; when one of the sums is zero the divider is skipped.
// A bar that yields no result holds the input off only while its typical
// price and flow are formed. A finished result waits in an output register
// while the next bar is taken; the input stalls longer only when that
// register is still full at the end of a bar.
module money_flow_index import mfi_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  mfi_bar_if.sink          bar,
  mfi_res_if.source        mfi
);

  state_t state;
  state_t state_next;

  logic [CFG_W-1:0]       window_length;
  logic [TP_SUM_W-1:0]    tp_sum;
  logic [2*TP_SUM_W-1:0]  tp_prod;
  logic [VOLUME_BITS-1:0] volume;
  logic [PRICE_BITS-1:0]  typical;
  logic [PRICE_BITS-1:0]  previous_typical;
  logic                   have_previous;
  logic [RING_AW-1:0]     ring_pointer;
  logic [RING_AW-1:0]     rd_addr;
  logic [RING_AW-1:0]     issue_cnt;
  logic [RING_AW-1:0]     win_m1;
  logic [CNT_W-1:0]       flow_count;
  logic [CNT_W-1:0]       count_next;
  logic [CNT_W-1:0]       win;
  logic                   data_valid;
  logic [SUM_W-1:0]       positive_sum;
  logic [SUM_W-1:0]       negative_sum;
  logic [TOTAL_W-1:0]     total;
  logic [NUM_W-1:0]       acc;
  logic [MFI_W-1:0]       mfi_result;
  logic [MFI_W-1:0]       out_value;
  logic                   out_valid;
  logic                   out_load;

  logic [TP_SUM_W-1:0]    q0;
  logic [TP_SUM_W-1:0]    rem3;
  logic [PRICE_BITS-1:0]  typical_next;
  logic [FLOW_W-1:0]      flow;

  logic                   ram_we;
  logic [ENTRY_W-1:0]     ram_wdata;
  logic [ENTRY_W-1:0]     ram_rdata;

  logic [NUM_W-1:0]       add_a;
  logic [NUM_W-1:0]       add_b;
  logic [NUM_W-1:0]       add_sum;

  logic                   div_start;
  div_stat_t              div_stat;
  logic [MFI_W-1:0]       div_q;

  // Effective window length.
  always_comb begin
    if (window_length == '0) begin
      win = CNT_W'(1);
    end else if (32'(window_length) > 32'(MAX_WINDOW)) begin
      win = CNT_W'(MAX_WINDOW);
    end else begin
      win = CNT_W'(window_length);
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
    end else if (cfg_we) begin
      window_length <= cfg_data;
    end
  end

  // Division by three: reciprocal estimate, then one correction step.
  always_comb begin
    q0           = TP_SUM_W'(tp_prod[2*TP_SUM_W-1:TP_SUM_W]);
    rem3         = tp_sum - ((q0 << 1) + q0);
    typical_next = (rem3 >= TP_SUM_W'(3)) ? PRICE_BITS'(q0 + 1'b1) : PRICE_BITS'(q0);
  end

  // Money flow of the current bar.
  assign flow      = FLOW_W'(typical) * FLOW_W'(volume);
  assign ram_wdata = {typical < previous_typical, flow};
  assign count_next = (flow_count == CNT_W'(MAX_WINDOW)) ? flow_count : flow_count + 1'b1;

  // Flow ring.
  mfi_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ring_pointer),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Shared wide adder: window sums, total, and the scaled numerator.
  always_comb begin
    add_a = '0;
    add_b = '0;
    case (state)
      ST_SUM, ST_LAST: begin
        add_a = ram_rdata[FLOW_W] ? NUM_W'(negative_sum) : NUM_W'(positive_sum);
        add_b = NUM_W'(ram_rdata[FLOW_W-1:0]);
      end
      ST_TOTAL: begin
        add_a = NUM_W'(positive_sum);
        add_b = NUM_W'(negative_sum);
      end
      ST_NUM_A: begin
        add_a = NUM_W'(positive_sum) << 14;
        add_b = NUM_W'(positive_sum) << 13;
      end
      ST_NUM_B: begin
        add_a = acc;
        add_b = NUM_W'(positive_sum) << 10;
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end
  assign add_sum = add_a + add_b;

  // Serial divider for the final ratio.
  mfi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (acc),
    .denom    (total),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (bar.valid) begin
          state_next = ST_TYPICAL;
        end
      end
      ST_TYPICAL: state_next = ST_FLOW;
      ST_FLOW: begin
        if (have_previous && (count_next >= win)) begin
          state_next = ST_SUM;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SUM: begin
        if (issue_cnt == win_m1) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: state_next = ST_TOTAL;
      ST_TOTAL: begin
        if ((negative_sum == '0) || (positive_sum == '0)) begin
          state_next = ST_PUT;
        end else begin
          state_next = ST_NUM_A;
        end
      end
      ST_NUM_A: state_next = ST_NUM_B;
      ST_NUM_B: state_next = ST_START;
      ST_START: state_next = ST_DIV;
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = ST_PUT;
        end
      end
      ST_PUT: begin
        if (!out_valid || mfi.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    bar.ready = 1'b0;
    ram_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE:  bar.ready = 1'b1;
      ST_FLOW:  ram_we    = have_previous;
      ST_START: div_start = 1'b1;
      ST_PUT:   out_load  = !out_valid || mfi.ready;
      default: begin
        bar.ready = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      have_previous    <= 1'b0;
      previous_typical <= '0;
      ring_pointer     <= '0;
      flow_count       <= '0;
      data_valid       <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      state      <= state_next;
      data_valid <= (state == ST_SUM);
      if (state == ST_FLOW) begin
        have_previous    <= 1'b1;
        previous_typical <= typical;
        if (have_previous) begin
          ring_pointer <= ring_pointer + 1'b1;
          flow_count   <= count_next;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (mfi.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        tp_sum  <= TP_SUM_W'(bar.bar_low) + TP_SUM_W'(bar.bar_high)
                   + TP_SUM_W'(bar.bar_close);
        tp_prod <= (2*TP_SUM_W)'(TP_SUM_W'(bar.bar_low) + TP_SUM_W'(bar.bar_high)
                   + TP_SUM_W'(bar.bar_close)) * (2*TP_SUM_W)'(RECIP3);
        volume  <= bar.bar_volume;
      end
      ST_TYPICAL: typical <= typical_next;
      ST_FLOW: begin
        rd_addr      <= ring_pointer;
        issue_cnt    <= '0;
        win_m1       <= RING_AW'(win - 1'b1);
        positive_sum <= '0;
        negative_sum <= '0;
      end
      ST_SUM, ST_LAST: begin
        if (state == ST_SUM) begin
          rd_addr   <= rd_addr - 1'b1;
          issue_cnt <= issue_cnt + 1'b1;
        end
        if (data_valid) begin
          if (ram_rdata[FLOW_W]) begin
            negative_sum <= add_sum[SUM_W-1:0];
          end else begin
            positive_sum <= add_sum[SUM_W-1:0];
          end
        end
      end
      ST_TOTAL: begin
        total <= add_sum[TOTAL_W-1:0];
        if (negative_sum == '0) begin
          mfi_result <= FULL_SCALE;
        end else begin
          mfi_result <= '0;
        end
      end
      ST_NUM_A, ST_NUM_B: acc <= add_sum;
      ST_DIV: begin
        if (div_stat.done) begin
          mfi_result <= div_q;
        end
      end
      ST_PUT: begin
        if (out_load) begin
          out_value <= mfi_result;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  assign mfi.valid     = out_valid;
  assign mfi.mfi_value = out_value;

`ifndef SYNTHESIS
  // Only written ring entries are ever summed.
  a_window_filled: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM) |-> (flow_count >= win))
    else $error("ring read before the window is full");

  // The divider reports completion only while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_DIV))
    else $error("divider finished outside its wait state");

  // The divider is idle whenever a new start is issued.
  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUT && out_valid && !mfi.ready) |=> (state == ST_PUT))
    else $error("result overwritten while waiting");

  // Results stay within full scale.
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_value <= FULL_SCALE))
    else $error("result above full scale");
`endif

endmodule

// ===== verif/money_flow_index_tb.sv =====
module money_flow_index_tb;
  import mfi_pkg::*;

  localparam int PRICE_MAX     = (1 << PRICE_BITS) - 1;
  localparam int N_DIRECTED    = 19;
  localparam int N_PHASES      = 10;
  localparam int BARS_PER_PHASE = 130;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 120;
  localparam int HOLD_AT       = 300;
  localparam int HOLD_CYCLES   = 400;
  localparam int TIMEOUT       = 3_200_000;

  typedef struct packed {
    logic [PRICE_BITS-1:0]  low;
    logic [PRICE_BITS-1:0]  high;
    logic [PRICE_BITS-1:0]  close;
    logic [VOLUME_BITS-1:0] volume;
  } bar_t;

  // How a row of the directed table is handled.
  typedef enum logic [1:0] {
    ROW_WINDOW,
    ROW_SILENT,
    ROW_KNOWN,
    ROW_PREDICT
  } row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    bar_t             b;
    logic [MFI_W-1:0] known;
    logic [CFG_W-1:0] window;
  } row_t;

  // Directed bars: window edge values, first bar, empty and one-sided windows.
  localparam row_t DIRECTED [N_DIRECTED] = '{
    '{ROW_WINDOW,  '{24'h000000, 24'h000000, 24'h000000, 32'h00000000}, 15'd0,     7'd0},
    '{ROW_SILENT,  '{24'h000000, 24'h000000, 24'h000000, 32'h00000000}, 15'd0,     7'd0},
    '{ROW_KNOWN,   '{24'h000000, 24'h000000, 24'h000000, 32'hFFFFFFFF}, 15'd25600, 7'd0},
    '{ROW_KNOWN,   '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF}, 15'd25600, 7'd0},
    '{ROW_KNOWN,   '{24'h800000, 24'h800000, 24'h800000, 32'h00000005}, 15'd0,     7'd0},
    '{ROW_KNOWN,   '{24'h000001, 24'h000001, 24'h000001, 32'h00000000}, 15'd25600, 7'd0},
    '{ROW_KNOWN,   '{24'hFFFFFF, 24'h000000, 24'hFFFFFF, 32'h00000001}, 15'd25600, 7'd0},
    '{ROW_WINDOW,  '{24'h000000, 24'h000000, 24'h000000, 32'h00000000}, 15'd0,     7'd3},
    '{ROW_PREDICT, '{24'h100000, 24'h300000, 24'h200000, 32'h00001000}, 15'd0,     7'd0},
    '{ROW_PREDICT, '{24'h300000, 24'h300000, 24'h300000, 32'h00003000}, 15'd0,     7'd0},
    '{ROW_PREDICT, '{24'h250000, 24'h250000, 24'h250000, 32'h0000FFFF}, 15'd0,     7'd0},
    '{ROW_PREDICT, '{24'h250000, 24'h250000, 24'h250000, 32'h12345678}, 15'd0,     7'd0},
    '{ROW_PREDICT, '{24'h000000, 24'hFFFFFF, 24'h000000, 32'h80000000}, 15'd0,     7'd0},
    '{ROW_PREDICT, '{24'h123456, 24'h654321, 24'h0ABCDE, 32'h00FF00FF}, 15'd0,     7'd0},
    '{ROW_WINDOW,  '{24'h000000, 24'h000000, 24'h000000, 32'h00000000}, 15'd0,     7'd2},
    '{ROW_KNOWN,   '{24'h000000, 24'h000000, 24'h000000, 32'hFFFFFFFF}, 15'd0,     7'd0},
    '{ROW_KNOWN,   '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'h00000000}, 15'd25600, 7'd0},
    '{ROW_KNOWN,   '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF}, 15'd25600, 7'd0},
    '{ROW_PREDICT, '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 32'hFFFFFFFF}, 15'd0,     7'd0}
  };

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_data;

  mfi_bar_if bar_ch ();
  mfi_res_if mfi_ch ();

  money_flow_index u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .bar      (bar_ch),
    .mfi      (mfi_ch)
  );

  // Expected index values, oldest first.
  logic [MFI_W-1:0] mfi_expected_q [$];
  int fails;
  int results_seen;
  logic calm;

  // Own copy of the block's state.
  logic [CFG_W-1:0]      win_reg;
  logic [PRICE_BITS-1:0] last_tp;
  logic                  seen_first;
  logic [FLOW_W-1:0]     flow_mem [MAX_WINDOW];
  logic                  fell_mem [MAX_WINDOW];
  logic [RING_AW-1:0]    wr_ptr;
  logic [CNT_W-1:0]      flows_held;

  // Random price walk and the last bar sent, for repeated bars.
  int   price_walk;
  bar_t last_bar;

  // Index that one bar produces, updating the state copy.
  function automatic void mfi_of_bar(input bar_t b, output logic got,
                                     output logic [MFI_W-1:0] val);
    logic [TP_SUM_W-1:0]   tp_sum;
    logic [PRICE_BITS-1:0] tp;
    logic [SUM_W-1:0]      pos;
    logic [SUM_W-1:0]      neg;
    logic [TOTAL_W-1:0]    total;
    logic [NUM_W-1:0]      num;
    int eff;
    int idx;
    got = 1'b0;
    val = '0;
    tp_sum = TP_SUM_W'(b.low) + TP_SUM_W'(b.high) + TP_SUM_W'(b.close);
    tp = PRICE_BITS'(tp_sum / 3);
    // The first bar only sets the reference price.
    if (!seen_first) begin
      last_tp = tp;
      seen_first = 1'b1;
      return;
    end
    flow_mem[wr_ptr] = FLOW_W'(tp) * FLOW_W'(b.volume);
    fell_mem[wr_ptr] = tp < last_tp;
    wr_ptr = wr_ptr + 1'b1;
    if (flows_held < MAX_WINDOW) flows_held = flows_held + 1'b1;
    last_tp = tp;
    // A zero window counts as one; oversized windows clip to the ring size.
    if (win_reg == 0) eff = 1;
    else if (win_reg > MAX_WINDOW) eff = MAX_WINDOW;
    else eff = int'(win_reg);
    if (flows_held < eff) return;
    pos = '0;
    neg = '0;
    for (int k = 0; k < eff; k++) begin
      idx = (int'(wr_ptr) + MAX_WINDOW - 1 - k) % MAX_WINDOW;
      if (fell_mem[idx]) neg = neg + SUM_W'(flow_mem[idx]);
      else pos = pos + SUM_W'(flow_mem[idx]);
    end
    total = TOTAL_W'(pos) + TOTAL_W'(neg);
    if (total == 0 || neg == 0) begin
      val = FULL_SCALE;
    end else if (pos == 0) begin
      val = '0;
    end else begin
      num = NUM_W'(pos) * NUM_W'(FULL_SCALE);
      val = MFI_W'(num / NUM_W'(total));
    end
    got = 1'b1;
  endfunction

  // Random bar: mostly a drifting price series, with jumps, repeats and extremes.
  function automatic bar_t next_bar();
    bar_t b;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        price_walk = price_walk + int'($urandom_range(0, 4000)) - 2000;
        if (price_walk < 4096) price_walk = 4096;
        if (price_walk > PRICE_MAX - 4096) price_walk = PRICE_MAX - 4096;
        b.low   = PRICE_BITS'(price_walk - int'($urandom_range(0, 4095)));
        b.high  = PRICE_BITS'(price_walk + int'($urandom_range(0, 4095)));
        b.close = PRICE_BITS'(price_walk - 2048 + int'($urandom_range(0, 4095)));
      end
      6: begin
        b.low   = PRICE_BITS'($urandom);
        b.high  = PRICE_BITS'($urandom);
        b.close = PRICE_BITS'($urandom);
        price_walk = int'($urandom_range(4096, PRICE_MAX - 4096));
      end
      7: begin
        b = last_bar;
      end
      8: begin
        b.low   = $urandom_range(0, 1) ? PRICE_BITS'(PRICE_MAX) : '0;
        b.high  = $urandom_range(0, 1) ? PRICE_BITS'(PRICE_MAX) : '0;
        b.close = $urandom_range(0, 1) ? PRICE_BITS'(PRICE_MAX) : '0;
      end
      default: begin
        price_walk = price_walk + int'($urandom_range(0, 2)) - 1;
        b.low   = PRICE_BITS'(price_walk);
        b.high  = PRICE_BITS'(price_walk);
        b.close = PRICE_BITS'(price_walk);
      end
    endcase
    case ($urandom_range(0, 7))
      4, 5:    b.volume = VOLUME_BITS'($urandom_range(0, 1000));
      6:       b.volume = '0;
      7:       b.volume = '1;
      default: b.volume = VOLUME_BITS'($urandom);
    endcase
    last_bar = b;
    return b;
  endfunction

  // Offers one bar after a random gap and records what it should produce.
  task automatic feed_bar(input bar_t b, input row_kind_t kind,
                          input logic [MFI_W-1:0] known);
    int gap;
    logic got;
    logic [MFI_W-1:0] val;
    gap = calm ? 0 : int'($urandom_range(0, 4));
    if (gap > 0) begin
      bar_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    bar_ch.valid      <= 1'b1;
    bar_ch.bar_low    <= b.low;
    bar_ch.bar_high   <= b.high;
    bar_ch.bar_close  <= b.close;
    bar_ch.bar_volume <= b.volume;
    do @(posedge clk); while (!bar_ch.ready);
    mfi_of_bar(b, got, val);
    if (kind == ROW_KNOWN) begin
      mfi_expected_q.insert(mfi_expected_q.size(), known);
    end else if (kind == ROW_PREDICT && got) begin
      mfi_expected_q.insert(mfi_expected_q.size(), val);
    end
  endtask

  // Changes the window only once the block has drained.
  task automatic write_window(input logic [CFG_W-1:0] w);
    bar_ch.valid <= 1'b0;
    while (mfi_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_reg = w;
  endtask

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: checks every transfer and stalls at random, once for a long stretch.
  initial begin : result_sink
    int stall;
    logic [MFI_W-1:0] want;
    stall = 0;
    mfi_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && mfi_ch.valid && mfi_ch.ready) begin
        results_seen++;
        if (mfi_expected_q.size() == 0) begin
          fails++;
          $error("mfi_value: expected no transfer, got %0d", mfi_ch.mfi_value);
        end else begin
          want = mfi_expected_q.pop_front();
          if (mfi_ch.mfi_value !== want) begin
            fails++;
            $error("mfi_value: expected %0d, got %0d", want, mfi_ch.mfi_value);
          end
        end
        if (results_seen == HOLD_AT) stall = HOLD_CYCLES;
        else stall = calm ? 0 : int'($urandom_range(0, 4));
      end
      mfi_ch.ready <= (stall == 0) && !rst;
      if (stall > 0) stall--;
    end
  end

  // Bar side: reset, directed table, then random phases with changing windows.
  initial begin : bar_source
    logic [CFG_W-1:0] w;
    fails = 0;
    results_seen = 0;
    calm = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    bar_ch.valid = 1'b0;
    bar_ch.bar_low = '0;
    bar_ch.bar_high = '0;
    bar_ch.bar_close = '0;
    bar_ch.bar_volume = '0;
    win_reg = WINDOW_RESET;
    last_tp = '0;
    seen_first = 1'b0;
    wr_ptr = '0;
    flows_held = '0;
    price_walk = PRICE_MAX / 2;
    last_bar = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].kind == ROW_WINDOW) write_window(DIRECTED[i].window);
      else feed_bar(DIRECTED[i].b, DIRECTED[i].kind, DIRECTED[i].known);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       w = CFG_W'(127);
        1:       w = CFG_W'(MAX_WINDOW);
        2:       w = CFG_W'(1);
        3:       w = '0;
        4:       w = WINDOW_RESET;
        default: w = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(65, 127))
                                                 : CFG_W'($urandom_range(1, 64));
      endcase
      write_window(w);
      calm = (ph % 4 == 2);
      for (int n = 0; n < BARS_PER_PHASE; n++) feed_bar(next_bar(), ROW_PREDICT, '0);
    end

    // Let the last results come out, then allow time for stray ones.
    bar_ch.valid <= 1'b0;
    calm = 1'b0;
    while (mfi_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop if the block hangs.
  initial begin : watchdog
    #(TIMEOUT);
    $display("Verification failed");
    $finish;
  end

endmodule
